/* design/rgb_luma_histogram_clip_assert.svh */
// Assertion macros used by the histogram top-level design file.
`ifndef RGB_LUMA_HISTOGRAM_CLIP_ASSERT_SVH
`define RGB_LUMA_HISTOGRAM_CLIP_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define RLH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RLH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* design/rlh_pkg.sv */
// ----------------------------------------------------------------------------
// rlh_pkg
// Shared constants, types and functions of the luma histogram block.
// ----------------------------------------------------------------------------
package rlh_pkg;
   localparam int BINS       = 256;
   localparam int COUNT_BITS = 24;
   localparam int NHIST      = 4;
   localparam int BIN_BITS   = $clog2(BINS);
   localparam int ADDR_BITS  = BIN_BITS + 2;
   localparam int VALUE_BITS = 24;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      KIND_PIXEL  = 2'd0,
      KIND_CLEAR  = 2'd1,
      KIND_FINISH = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;

   // Bin of a component or luma value; values beyond the bins go to the top bin.
   function automatic logic [BIN_BITS-1:0] bin_of(input logic [7:0] v);
      logic [8:0] wide;
      wide = {1'b0, v};
      if (wide >= 9'(BINS)) begin
         bin_of = BIN_BITS'(BINS - 1);
      end else begin
         bin_of = v[BIN_BITS-1:0];
      end
   endfunction

   // Count clamped to the output width.
   function automatic logic [VALUE_BITS-1:0] out_value(input count_type v);
      logic [32:0] wide;
      wide = 33'(v);
      if (wide > 33'((64'd1 << VALUE_BITS) - 1)) begin
         out_value = {VALUE_BITS{1'b1}};
      end else begin
         out_value = VALUE_BITS'(wide);
      end
   endfunction
endpackage

/* design/rlh_luma.sv */
// ----------------------------------------------------------------------------
// rlh_luma
// Pipelined luma weighting: products registered, then summed combinationally.
// ----------------------------------------------------------------------------
module rlh_luma (
   input  logic       clock,
   input  logic       enable,
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   output logic [7:0] luma
);
   logic [23:0] pr_ff, pg_ff, pb_ff;
   logic [23:0] sum;

   always_ff @(posedge clock) begin
      if (enable) begin
         pr_ff <= 24'(16'd13938 * red);
         pg_ff <= 24'(16'd46869 * green);
         pb_ff <= 24'(16'd4730 * blue);
      end
   end

   // The weights sum to 65537, and 255 times that still lies below 256 << 16,
   // so the sum fits 24 bits and the luma never exceeds 255.
   assign sum  = pr_ff + pg_ff + pb_ff;
   assign luma = sum[23:16];
endmodule

/* design/rlh_bin_ram.sv */
// ----------------------------------------------------------------------------
// rlh_bin_ram
// Bin counter memory: one write and one registered read port.
// ----------------------------------------------------------------------------
module rlh_bin_ram (
   input  logic                clock,
   input  logic                wr_en,
   input  rlh_pkg::addr_type   wr_addr,
   input  rlh_pkg::count_type  wr_data,
   input  logic                rd_en,
   input  rlh_pkg::addr_type   rd_addr,
   output rlh_pkg::count_type  rd_data
);
   rlh_pkg::count_type mem [rlh_pkg::NHIST*rlh_pkg::BINS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

/* design/rgb_luma_histogram_clip.sv */
// ----------------------------------------------------------------------------
// rgb_luma_histogram_clip
// Red, green, blue and luma histograms with saturating bins and a clip pass.
// ----------------------------------------------------------------------------
// Each word is handled on its own. For a pixel, the luma products are
// registered and then the summed luma is registered; then the four
// histograms are each read, incremented and written back through the single
// bin memory, in a read state and a write state per histogram, since its one
// read port sets the pace. A read fetches its bin, then offers it. A clear
// sweeps the memory one bin a cycle. A finish runs per histogram one scan
// pass, one clip pass and one offer of the limit, with the four clip limits
// offered in channel order and last on the fourth; each limit also waits
// while the previous result word is still held by a stall. A result waiting
// in the output register does not hold off the next word; only a word that
// itself gives a result waits for it. After reset the block runs a clearing
// pass over all four histograms during which no word is accepted.
module rgb_luma_histogram_clip (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [1:0]  req_hist_select,
   input  logic [7:0]  req_bin_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_channel,
   output logic [23:0] rsp_value,
   output logic        rsp_last
);
`include "rgb_luma_histogram_clip_assert.svh"

   localparam int BB = rlh_pkg::BIN_BITS;
   localparam int AB = rlh_pkg::ADDR_BITS;
   localparam int CB = rlh_pkg::COUNT_BITS;
   localparam int RECIP_SHIFT = CB + 3;
   localparam logic [CB:0] RECIP_FIFTH =
      (CB+1)'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CLEAR = 9'b000000010,
      ST_LUMA  = 9'b000000100,
      ST_PIXRD = 9'b000001000,
      ST_PIXWR = 9'b000010000,
      ST_SCAN  = 9'b000100000,
      ST_CLIP  = 9'b001000000,
      ST_READ  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]  hist_ff, hist_in;          // histogram being worked on
   logic [BB:0] pos_ff, pos_in;            // sweep position, one spare bit
   logic        phase_ff, phase_in;        // luma pipeline step
   logic [1:0]  kind_ff;
   logic [7:0]  r_ff, g_ff, b_ff, idx_ff;
   logic [1:0]  sel_ff;
   rlh_pkg::count_type first_ff, first_in, second_ff, second_in, limit_ff, limit_in;
   logic        rvalid_ff, rvalid_in;
   logic [1:0]  rchan_ff, rchan_in;
   logic [23:0] rvalue_ff, rvalue_in;
   logic        rlast_ff, rlast_in;
   logic        rd_pend_ff, rd_pend_in;    // memory data is valid next cycle
   logic [BB-1:0] rd_bin_ff, rd_bin_in;    // bin whose data is in flight

   logic [7:0]  luma;
   logic [7:0]  luma_ff;
   logic        wr_en, rd_en;
   rlh_pkg::addr_type wr_addr, rd_addr;
   rlh_pkg::count_type wr_data, rd_data;
   logic        accept;
   logic [2*CB:0] fifth_prod;
   logic [CB+2:0] lim_wide;
   logic [BB-1:0] pix_bin;

   rlh_luma u_luma (
      .clock (clock),
      .enable(state_ff == ST_LUMA && !phase_ff),
      .red   (r_ff),
      .green (g_ff),
      .blue  (b_ff),
      .luma  (luma)
   );

   rlh_bin_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rvalid_ff;
   assign rsp_channel = rchan_ff;
   assign rsp_value   = rvalue_ff;
   assign rsp_last    = rlast_ff;

   // Bin touched by the pixel in the histogram currently addressed.
   always_comb begin
      case (hist_ff)
         2'd0:    pix_bin = rlh_pkg::bin_of(luma_ff);
         2'd1:    pix_bin = rlh_pkg::bin_of(r_ff);
         2'd2:    pix_bin = rlh_pkg::bin_of(g_ff);
         default: pix_bin = rlh_pkg::bin_of(b_ff);
      endcase
   end

   // Six fifths of the second maximum is the count plus a fifth of it. The
   // fifth comes from a multiplication by the rounded-up reciprocal, which is
   // exact for every count of the counter width.
   assign fifth_prod = (2*CB+1)'(second_ff) * (2*CB+1)'(RECIP_FIFTH);
   assign lim_wide   = (CB+3)'(second_ff) + (CB+3)'(fifth_prod >> RECIP_SHIFT);

   always_comb begin
      state_in  = state_ff;
      hist_in   = hist_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      limit_in  = limit_ff;
      rvalid_in = rvalid_ff;
      rchan_in  = rchan_ff;
      rvalue_in = rvalue_ff;
      rlast_in  = rlast_ff;
      rd_pend_in = 1'b0;
      rd_bin_in = rd_bin_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_en     = 1'b0;
      rd_addr   = '0;

      if (rvalid_ff && !rsp_stall) begin
         rvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hist_in = 2'd0;
               pos_in  = '0;
               unique case (rlh_pkg::kind_type'(req_kind))
                  rlh_pkg::KIND_PIXEL:  begin state_in = ST_LUMA; phase_in = 1'b0; end
                  rlh_pkg::KIND_CLEAR:  state_in = ST_CLEAR;
                  rlh_pkg::KIND_FINISH: begin
                     state_in  = ST_SCAN;
                     first_in  = CB'(1);
                     second_in = CB'(1);
                  end
                  default:              state_in = ST_READ;
               endcase
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = {hist_ff, pos_ff[BB-1:0]};
            if (pos_ff[BB-1:0] == BB'(rlh_pkg::BINS - 1)) begin
               pos_in  = '0;
               hist_in = hist_ff + 2'd1;
               if (hist_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_LUMA: begin
            phase_in = 1'b1;
            if (phase_ff) begin
               state_in = ST_PIXRD;
            end
         end
         ST_PIXRD: begin
            rd_en    = 1'b1;
            rd_addr  = {hist_ff, pix_bin};
            state_in = ST_PIXWR;
         end
         ST_PIXWR: begin
            wr_en   = rd_data != rlh_pkg::COUNT_MAX;
            wr_addr = {hist_ff, pix_bin};
            wr_data = rd_data + 1'b1;
            hist_in = hist_ff + 2'd1;
            state_in = (hist_ff == 2'd3) ? ST_IDLE : ST_PIXRD;
         end
         ST_SCAN: begin
            // Reads issue one bin a cycle; the data of each is tracked in the cycle after its read.
            if (!pos_ff[BB]) begin
               rd_en      = 1'b1;
               rd_addr    = {hist_ff, pos_ff[BB-1:0]};
               rd_pend_in = 1'b1;
               rd_bin_in  = pos_ff[BB-1:0];
               pos_in     = pos_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               if (first_ff < rd_data) begin
                  first_in = rd_data;
               end else if (second_ff < rd_data && second_ff < first_ff) begin
                  second_in = rd_data;
               end
            end
            if (pos_ff[BB] && !rd_pend_ff) begin
               if (lim_wide > (CB+3)'(rlh_pkg::COUNT_MAX)) begin
                  limit_in = rlh_pkg::COUNT_MAX;
               end else begin
                  limit_in = CB'(lim_wide);
               end
               pos_in   = '0;
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            // Read one bin, write the clipped value of the previous one.
            if (!pos_ff[BB]) begin
               rd_en      = 1'b1;
               rd_addr    = {hist_ff, pos_ff[BB-1:0]};
               rd_pend_in = 1'b1;
               rd_bin_in  = pos_ff[BB-1:0];
               pos_in     = pos_ff + 1'b1;
            end
            if (rd_pend_ff && rd_data > limit_ff) begin
               wr_en   = 1'b1;
               wr_addr = {hist_ff, rd_bin_ff};
               wr_data = limit_ff;
            end
            if (pos_ff[BB] && !rd_pend_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_READ: begin
            if (!rd_pend_ff) begin
               rd_en      = 1'b1;
               rd_addr    = {sel_ff, idx_ff[BB-1:0]};
               rd_pend_in = 1'b1;
               hist_in    = sel_ff;
               limit_in   = '0;
            end else begin
               limit_in = ({1'b0, idx_ff} < 9'(rlh_pkg::BINS)) ? rd_data : '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rvalid_ff) begin
               rvalid_in = 1'b1;
               rchan_in  = hist_ff;
               rvalue_in = rlh_pkg::out_value(limit_ff);
               rlast_in  = (kind_ff == rlh_pkg::KIND_READ) || (hist_ff == 2'd3);
               if (rlast_in) begin
                  state_in = ST_IDLE;
               end else begin
                  hist_in   = hist_ff + 2'd1;
                  pos_in    = '0;
                  first_in  = CB'(1);
                  second_in = CB'(1);
                  state_in  = ST_SCAN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         hist_ff    <= 2'd0;
         pos_ff     <= '0;
         phase_ff   <= 1'b0;
         rvalid_ff  <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         hist_ff    <= hist_in;
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         rvalid_ff  <= rvalid_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
      limit_ff  <= limit_in;
      rchan_ff  <= rchan_in;
      rvalue_ff <= rvalue_in;
      rlast_ff  <= rlast_in;
      rd_bin_ff <= rd_bin_in;
      if (state_ff == ST_LUMA && phase_ff) begin
         luma_ff <= luma;
      end
      if (accept) begin
         kind_ff <= req_kind;
         r_ff    <= req_red;
         g_ff    <= req_green;
         b_ff    <= req_blue;
         sel_ff  <= req_hist_select;
         idx_ff  <= req_bin_index;
      end
   end

   `RLH_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !accept)
   `RLH_ASSERT_IMP(a_onehot_state, clock, reset, 1'b1, $onehot(state_ff))
   `RLH_ASSERT_IMP(a_second_le_first, clock, reset, state_ff == ST_SCAN,
      second_ff <= first_ff || second_ff == CB'(1))
   `RLH_ASSERT_NEXT(a_rsp_hold, clock, reset, rvalid_ff && rsp_stall,
      rvalid_ff && $stable(rvalue_ff))
endmodule

/* sim/rgb_luma_histogram_clip_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_luma_histogram_clip_checker
// Watches both channels of the histogram block, keeps its own copy of the
// four histograms, predicts every result word and compares it on arrival.
// ----------------------------------------------------------------------------
module rgb_luma_histogram_clip_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [1:0]  req_hist_select,
   input  logic [7:0]  req_bin_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_channel,
   input  logic [23:0] rsp_value,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic [1:0]  channel;
      logic [23:0] value;
      logic        last;
   } result_word_type;

   rlh_pkg::count_type hist_model [rlh_pkg::NHIST][rlh_pkg::BINS];
   result_word_type    result_fifo [$];

   assign pending = result_fifo.size();

   function automatic logic [23:0] clamp_value(input logic [31:0] v);
      return (v > 32'hFFFFFF) ? 24'hFFFFFF : v[23:0];
   endfunction

   task automatic count_bin(input int h, input int v);
      int b;
      b = (v >= rlh_pkg::BINS) ? rlh_pkg::BINS - 1 : v;
      if (hist_model[h][b] != rlh_pkg::COUNT_MAX) hist_model[h][b] = hist_model[h][b] + 1'b1;
   endtask

   // Second-maximum search, then clip every bin to 6/5 of it.
   function automatic logic [31:0] clip_channel(input int h);
      logic [63:0] top, second, limit;
      top = 1;
      second = 1;
      for (int i = 0; i < rlh_pkg::BINS; i++) begin
         if (top < hist_model[h][i]) top = hist_model[h][i];
         else if (second < hist_model[h][i] && second < top) second = hist_model[h][i];
      end
      limit = (second * 6) / 5;
      if (limit > rlh_pkg::COUNT_MAX) limit = rlh_pkg::COUNT_MAX;
      for (int i = 0; i < rlh_pkg::BINS; i++)
         if (hist_model[h][i] > limit) hist_model[h][i] = limit[rlh_pkg::COUNT_BITS-1:0];
      return limit[31:0];
   endfunction

   task automatic apply_word();
      int luma;
      result_word_type w;
      case (rlh_pkg::kind_type'(req_kind))
         rlh_pkg::KIND_PIXEL: begin
            luma = (13938 * req_red + 46869 * req_green + 4730 * req_blue) >> 16;
            if (luma > 255) luma = 255;
            count_bin(0, luma);
            count_bin(1, req_red);
            count_bin(2, req_green);
            count_bin(3, req_blue);
         end
         rlh_pkg::KIND_CLEAR: begin
            foreach (hist_model[h, i]) hist_model[h][i] = '0;
         end
         rlh_pkg::KIND_FINISH: begin
            for (int h = 0; h < rlh_pkg::NHIST; h++) begin
               w.channel = h[1:0];
               w.value   = clamp_value(clip_channel(h));
               w.last    = (h == rlh_pkg::NHIST - 1);
               result_fifo.push_back(w);
            end
         end
         default: begin
            w.channel = req_hist_select;
            w.value   = (req_bin_index < rlh_pkg::BINS) ?
                        clamp_value(32'(hist_model[req_hist_select][req_bin_index])) : '0;
            w.last    = 1'b1;
            result_fifo.push_back(w);
         end
      endcase
   endtask

   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         foreach (hist_model[h, i]) hist_model[h][i] = '0;
         result_fifo.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) apply_word();
         if (rsp_valid && !rsp_stall) begin
            if (result_fifo.size() == 0) begin
               $error("unexpected result word: channel %0d value %0d", rsp_channel, rsp_value);
               fail_count <= fail_count + 1;
            end else begin
               want = result_fifo.pop_front();
               if (want.channel !== rsp_channel || want.value !== rsp_value ||
                   want.last !== rsp_last) begin
                  if (want.channel !== rsp_channel)
                     $error("channel: expected %0d, got %0d", want.channel, rsp_channel);
                  if (want.value !== rsp_value)
                     $error("value: expected %0d, got %0d", want.value, rsp_value);
                  if (want.last !== rsp_last)
                     $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   initial fail_count = 0;
endmodule

/* sim/rgb_luma_histogram_clip_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_luma_histogram_clip_tb
// Drives pixel, clear, finish and read words into the histogram block under
// several idling patterns; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module rgb_luma_histogram_clip_tb;
   // Slowest word is a finish: a scan and a clip pass per histogram plus four
   // results, each possibly held by a long stall. The limit is that times the word
   // count several times over, plus the clearing pass after reset.
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int DRAIN_CYCLES = 4 * (2 * rlh_pkg::BINS + 8);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = rlh_pkg::KIND_PIXEL;
   logic [7:0]  req_red = '0, req_green = '0, req_blue = '0;
   logic [1:0]  req_hist_select = '0;
   logic [7:0]  req_bin_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_channel;
   logic [23:0] rsp_value;
   logic        rsp_last;
   int          fail_count, pending;
   int          cycle_count = 0;
   int          send_idle = 0, recv_stall = 0;   // percentages of idle cycles

   always #5 clock = ~clock;

   rgb_luma_histogram_clip u_top (.*);

   rgb_luma_histogram_clip_checker u_checker (.*);

   // The run is ended here if it ever hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // The receiver stalls at random, changing only at the falling edge.
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall);

   // Present one word at a falling edge and hold it until it is taken. The
   // task returns at the accepting rising edge with valid still high; the
   // next word or stop_sending lowers or replaces it at the next falling edge.
   task automatic send_word(input rlh_pkg::kind_type k, input logic [7:0] r, g, b,
                            input logic [1:0] sel, input logic [7:0] idx);
      @(negedge clock);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      req_hist_select <= sel;
      req_bin_index <= idx;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid after the last word of a burst.
   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_pixel(input logic [7:0] r, g, b);
      send_word(rlh_pkg::KIND_PIXEL, r, g, b, 2'($urandom), 8'($urandom));
   endtask

   task automatic send_read(input logic [1:0] sel, input logic [7:0] idx);
      send_word(rlh_pkg::KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), sel, idx);
   endtask

   task automatic send_control(input rlh_pkg::kind_type k);
      send_word(k, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
   endtask

   // A random frame: mostly pixels, about a third of them of one hot value so that
   // the clip bites, then a finish (sometimes after a clear) and three reads of the hot bin.
   task automatic random_frame(input int pixels);
      logic [7:0] hot;
      hot = 8'($urandom);
      for (int i = 0; i < pixels; i++) begin
         if ($urandom_range(2) == 0)
            send_pixel(hot, hot, hot);
         else
            send_pixel(8'($urandom), 8'($urandom_range(255)), 8'($urandom));
         if ($urandom_range(15) == 0) send_read(2'($urandom), 8'($urandom));
      end
      if ($urandom_range(7) == 0) send_control(rlh_pkg::KIND_CLEAR);
      send_control(rlh_pkg::KIND_FINISH);
      for (int i = 0; i < 3; i++) send_read(2'($urandom), hot);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words: component extremes, reads of fresh and counted bins,
      // the tracker starting values on an empty histogram, clear and finish.
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'h55, 8'hAA, 8'h55);
      send_read(2'd0, 8'd255);
      send_read(2'd1, 8'd0);
      send_read(2'd2, 8'd255);
      send_read(2'd3, 8'hAA);
      send_control(rlh_pkg::KIND_FINISH);
      send_read(2'd0, 8'd255);
      send_read(2'd3, 8'd255);
      send_control(rlh_pkg::KIND_CLEAR);
      send_read(2'd1, 8'd255);
      send_control(rlh_pkg::KIND_FINISH);
      for (int i = 0; i < 5; i++) send_pixel(8'd7, 8'd7, 8'd7);
      send_pixel(8'd9, 8'd9, 8'd9);
      send_pixel(8'd9, 8'd9, 8'd9);
      send_control(rlh_pkg::KIND_FINISH);
      send_read(2'd2, 8'd7);

      // Random frames under each idling pattern.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 81; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 81; end
            default: begin send_idle = 9; recv_stall = 9; end
         endcase
         random_frame(12 + $urandom_range(8));
         // The sender holds off until every result is back.
         stop_sending();
         while (pending != 0) @(negedge clock);
         random_frame(6 + $urandom_range(6));
      end

      stop_sending();
      while (pending != 0) @(negedge clock);
      recv_stall = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

/* files.f */
+incdir+design
design/rlh_pkg.sv
design/rlh_luma.sv
design/rlh_bin_ram.sv
design/rgb_luma_histogram_clip.sv
sim/rgb_luma_histogram_clip_checker.sv
sim/rgb_luma_histogram_clip_tb.sv
